// ===== design/biquad_iir_filter_defines.svh =====
// Assertion macros used by the filter design file biquad_iir_filter.sv.
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

`define BQD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad check failed");

`define BQD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad check failed");

`else

`define BQD_ASSERT_NOW(lbl, ante, cons)

`define BQD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/bqd_pkg.sv =====
`timescale 1ns / 1ps

package bqd_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int CHAN_W       = 3;
  localparam int COEF_W       = 32;
  localparam int COEF_FRAC    = 28;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int ACC_W        = PROD_W + 4;
  localparam int Q_W          = ACC_W - COEF_FRAC;
  localparam int CHANNELS_DEF = 8;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_B1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A1 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_A2 = CFG_IDX_W'(4);

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          chan_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHAN_W-1:0]          chan_out;
  } out_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_t;

endpackage

// ===== design/bqd_hist.sv =====
`timescale 1ns / 1ps

module bqd_hist #(
  parameter int DEPTH = bqd_pkg::CHANNELS_DEF,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output bqd_pkg::hist_t  rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  bqd_pkg::hist_t  wr_data
);

  bqd_pkg::hist_t mem [DEPTH];
  bqd_pkg::hist_t mem_rd_r;
  logic [DEPTH-1:0] vld_r;
  logic             vld_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_rd_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r <= mem[rd_addr];
    end
  end

  // never-written entries read as cleared history
  assign rd_data = vld_rd_r ? mem_rd_r : '0;

endmodule

// ===== design/biquad_iir_filter.sv =====
`timescale 1ns / 1ps
// Channel   Ports                              Word
// input     in_valid, in_ready, in_data        bqd_pkg::in_word_t (sample, channel)
// result    out_valid, out_ready, out_data     bqd_pkg::out_word_t (sample, channel)
// config    cfg_wr_en, cfg_index, cfg_data     Q4.28 coefficient, index 0..4
//
// Each accepted word passes the history memory read stage (s1), the multiply
// stage (s2), the partial sums stage (s3) and the final sum and saturate into the
// output register; one word per cycle while out_ready holds and no word names a
// channel that is still in flight. A word whose channel is still in s1, s2 or s3 waits.
// Synchronous reset empties the pipeline, clears all channel history and loads
// b0 = 1.0, other coefficients 0. A stalled result holds the output register;
// stages behind it keep filling until stage one cannot move, then in_ready drops.
`include "biquad_iir_filter_defines.svh"

module biquad_iir_filter #(
  parameter int CHANNELS = bqd_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bqd_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bqd_pkg::out_word_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [bqd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bqd_pkg::COEF_W-1:0]      cfg_data
);

  localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHW = (AW > bqd_pkg::CHAN_W) ? AW : bqd_pkg::CHAN_W;

  logic signed [bqd_pkg::COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;

  logic                                s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic signed [bqd_pkg::SAMPLE_W-1:0] s1_x_r, s2_x_r, s2_x1_r, s2_y1_r;
  logic signed [bqd_pkg::SAMPLE_W-1:0] s3_x_r, s3_x1_r, s3_y1_r;
  logic [bqd_pkg::CHAN_W-1:0]          s1_chan_r, s2_chan_r, s3_chan_r;
  logic                                s1_inr_r, s2_inr_r, s3_inr_r;
  logic signed [bqd_pkg::PROD_W-1:0]   p0_r, p1_r, p2_r, p3_r, p4_r;
  logic signed [bqd_pkg::PROD_W-1:0]   p0_nxt, p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic signed [bqd_pkg::ACC_W-1:0]    sa_r, sb_r, sa_nxt, sb_nxt, acc_nxt;
  logic signed [bqd_pkg::Q_W-1:0]      q_nxt;
  logic signed [bqd_pkg::SAMPLE_W-1:0] y_nxt;
  bqd_pkg::out_word_t                  out_data_r, out_data_nxt;

  logic            out_free, adv1, adv2, adv3, s1_free, s2_free, s3_free;
  logic            hazard, in_acc, in_inr;
  logic [CHW-1:0]  in_chan_ext, s3_chan_ext;
  logic [AW-1:0]   in_addr, s3_addr;
  bqd_pkg::hist_t  hist_rd, hist_wr;
  logic            hist_we;

  // ---------------------------------------------------------------- control
  assign in_chan_ext = CHW'(in_data.chan_in);
  assign in_addr     = in_chan_ext[AW-1:0];
  assign in_inr      = ({1'b0, in_chan_ext} < (CHW+1)'(CHANNELS));

  assign hazard = (s1_v_r && (s1_chan_r == in_data.chan_in)) ||
                  (s2_v_r && (s2_chan_r == in_data.chan_in)) ||
                  (s3_v_r && (s3_chan_r == in_data.chan_in));

  assign out_free = !out_valid_r || out_ready;
  assign adv3     = s3_v_r && out_free;
  assign s3_free  = !s3_v_r || adv3;
  assign adv2     = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || adv2;
  assign adv1     = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || adv1;

  assign in_ready = s1_free && !hazard;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------- history
  assign s3_chan_ext = CHW'(s3_chan_r);
  assign s3_addr     = s3_chan_ext[AW-1:0];
  assign hist_we     = adv3 && s3_inr_r;
  assign hist_wr     = '{x1: s3_x_r, x2: s3_x1_r, y1: y_nxt, y2: s3_y1_r};

  bqd_hist #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && in_inr),
    .rd_addr (in_addr),
    .rd_data (hist_rd),
    .wr_en   (hist_we),
    .wr_addr (s3_addr),
    .wr_data (hist_wr)
  );

  // ---------------------------------------------------------------- datapath
  assign p0_nxt = coef_b0_r * s1_x_r;
  assign p1_nxt = coef_b1_r * hist_rd.x1;
  assign p2_nxt = coef_b2_r * hist_rd.x2;
  assign p3_nxt = coef_a1_r * hist_rd.y1;
  assign p4_nxt = coef_a2_r * hist_rd.y2;

  assign sa_nxt = bqd_pkg::ACC_W'(p0_r) + bqd_pkg::ACC_W'(p1_r) + bqd_pkg::ACC_W'(p2_r) +
                  bqd_pkg::ROUND_HALF;
  assign sb_nxt = bqd_pkg::ACC_W'(p3_r) + bqd_pkg::ACC_W'(p4_r);

  assign acc_nxt = sa_r - sb_r;
  assign q_nxt   = $signed(acc_nxt[bqd_pkg::ACC_W-1:bqd_pkg::COEF_FRAC]);

  always_comb begin
    priority if (q_nxt > bqd_pkg::Q_W'(bqd_pkg::SAT_MAX)) begin
      y_nxt = bqd_pkg::SAT_MAX;
    end else if (q_nxt < bqd_pkg::Q_W'(bqd_pkg::SAT_MIN)) begin
      y_nxt = bqd_pkg::SAT_MIN;
    end else begin
      y_nxt = q_nxt[bqd_pkg::SAMPLE_W-1:0];
    end
  end

  always_comb begin
    out_data_nxt.sample_out = s3_inr_r ? y_nxt : '0;
    out_data_nxt.chan_out   = s3_chan_r;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      coef_b0_r   <= bqd_pkg::COEF_ONE;
      coef_b1_r   <= '0;
      coef_b2_r   <= '0;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_acc;
      end
      if (s2_free) begin
        s2_v_r <= adv1;
      end
      if (s3_free) begin
        s3_v_r <= adv2;
      end
      if (out_free) begin
        out_valid_r <= adv3;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bqd_pkg::REG_B0: coef_b0_r <= cfg_data;
          bqd_pkg::REG_B1: coef_b1_r <= cfg_data;
          bqd_pkg::REG_B2: coef_b2_r <= cfg_data;
          bqd_pkg::REG_A1: coef_a1_r <= cfg_data;
          bqd_pkg::REG_A2: coef_a2_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= in_data.sample_in;
      s1_chan_r <= in_data.chan_in;
      s1_inr_r  <= in_inr;
    end
    if (adv1) begin
      p0_r      <= p0_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      p4_r      <= p4_nxt;
      s2_x_r    <= s1_x_r;
      s2_x1_r   <= hist_rd.x1;
      s2_y1_r   <= hist_rd.y1;
      s2_chan_r <= s1_chan_r;
      s2_inr_r  <= s1_inr_r;
    end
    if (adv2) begin
      sa_r      <= sa_nxt;
      sb_r      <= sb_nxt;
      s3_x_r    <= s2_x_r;
      s3_x1_r   <= s2_x1_r;
      s3_y1_r   <= s2_y1_r;
      s3_chan_r <= s2_chan_r;
      s3_inr_r  <= s2_inr_r;
    end
    if (adv3) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- checks
  `BQD_ASSERT_NOW(a_chan_s1_s2, s1_v_r && s2_v_r, s1_chan_r != s2_chan_r)
  `BQD_ASSERT_NOW(a_chan_s1_s3, s1_v_r && s3_v_r, s1_chan_r != s3_chan_r)
  `BQD_ASSERT_NOW(a_chan_s2_s3, s2_v_r && s3_v_r, s2_chan_r != s3_chan_r)
  `BQD_ASSERT_NEXT(a_s3_hold, s3_v_r && out_valid_r && !out_ready, s3_v_r && $stable(s3_chan_r))

endmodule
